// File: hdl/skac_pkg.sv
// Shared types, register codes and defaults for the soft-knee compressor.
package skac_pkg;

    // Default geometry of the two lookup tables
    localparam int DEF_LEVEL_TABLE_DEPTH = 1024;
    localparam int DEF_LEVEL_INDEX_SHIFT = 5;
    localparam int DEF_GAIN_TABLE_DEPTH  = 1024;
    localparam int DEF_GAIN_INDEX_SHIFT  = 4;

    // Item opcodes
    localparam logic [1:0] OP_SAMPLE   = 2'd0;
    localparam logic [1:0] OP_LEVEL_WR = 2'd1;
    localparam logic [1:0] OP_GAIN_WR  = 2'd2;

    // Configuration port geometry and register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOPE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KNEE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_FOUR  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAKEUP    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_BASE = 3'd7;

    // Register reset values
    localparam logic signed [15:0] RST_THRESHOLD = 16'sd0;
    localparam logic        [16:0] RST_SLOPE     = 17'd32768;
    localparam logic        [13:0] RST_KNEE      = 14'd384;
    localparam logic        [15:0] RST_INV_FOUR  = 16'd683;
    localparam logic signed [14:0] RST_MAKEUP    = 15'sd768;
    localparam logic        [15:0] RST_ATTACK    = 16'd65509;
    localparam logic        [15:0] RST_RELEASE   = 16'd65522;
    localparam logic signed [15:0] RST_GAIN_BASE = -16'sd24576;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 31;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic signed [15:0] threshold_db;
        logic        [16:0] slope;
        logic        [13:0] knee_half_width;
        logic        [15:0] inv_four_width;
        logic signed [14:0] makeup_db;
        logic        [15:0] attack_coef;
        logic        [15:0] release_coef;
        logic signed [15:0] gain_table_base_db;
    } cfg_t;

    typedef struct packed {
        logic        [1:0]  opcode;
        logic signed [15:0] sample_in;
        logic        [9:0]  table_index;
        logic        [15:0] table_word;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               compressing;
    } out_item_t;

endpackage

// File: hdl/skac_cfg.sv
// Configuration register file of the soft-knee compressor.
module skac_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [skac_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [skac_pkg::CFG_DATA_W-1:0]    cfg_data,
    output skac_pkg::cfg_t                     cfg
);

    skac_pkg::cfg_t cfg_reg;

    // Load the addressed register on a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_db       <= skac_pkg::RST_THRESHOLD;
            cfg_reg.slope              <= skac_pkg::RST_SLOPE;
            cfg_reg.knee_half_width    <= skac_pkg::RST_KNEE;
            cfg_reg.inv_four_width     <= skac_pkg::RST_INV_FOUR;
            cfg_reg.makeup_db          <= skac_pkg::RST_MAKEUP;
            cfg_reg.attack_coef        <= skac_pkg::RST_ATTACK;
            cfg_reg.release_coef       <= skac_pkg::RST_RELEASE;
            cfg_reg.gain_table_base_db <= skac_pkg::RST_GAIN_BASE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                skac_pkg::CFG_THRESHOLD: cfg_reg.threshold_db    <= signed'(cfg_data[15:0]);
                skac_pkg::CFG_SLOPE:     cfg_reg.slope           <= cfg_data[16:0];
                skac_pkg::CFG_KNEE:      cfg_reg.knee_half_width <= cfg_data[13:0];
                skac_pkg::CFG_INV_FOUR:  cfg_reg.inv_four_width  <= cfg_data[15:0];
                skac_pkg::CFG_MAKEUP:    cfg_reg.makeup_db       <= signed'(cfg_data[14:0]);
                skac_pkg::CFG_ATTACK:    cfg_reg.attack_coef     <= cfg_data[15:0];
                skac_pkg::CFG_RELEASE:   cfg_reg.release_coef    <= cfg_data[15:0];
                skac_pkg::CFG_GAIN_BASE:
                    cfg_reg.gain_table_base_db <= signed'(cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/skac_ram.sv
// Single-port-write, single-port-read table memory with registered read data.
module skac_ram #(
    parameter int DEPTH = skac_pkg::DEF_LEVEL_TABLE_DEPTH,
    parameter int WIDTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write the addressed entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/skac_mul.sv
// Shared signed multiplier with a registered product.
module skac_mul (
    input  logic                                 clk,
    input  logic signed [skac_pkg::MUL_A_W-1:0]  a,
    input  logic signed [skac_pkg::MUL_B_W-1:0]  b,
    output logic signed [skac_pkg::MUL_P_W-1:0]  product
);

    logic signed [skac_pkg::MUL_P_W-1:0] product_reg;

    // Multiply and hold the product for the next step
    always_ff @(posedge clk)
    begin
        product_reg <= skac_pkg::MUL_P_W'(a) * skac_pkg::MUL_P_W'(b);
    end

    assign product = product_reg;

endmodule

// File: hdl/soft_knee_audio_compressor_unit.sv
// Top level of the soft-knee compressor: sequencer, datapath and table memories.
//
//   channel   direction  handshake                payload
//   item      in         item_valid / item_stall  skac_pkg::in_item_t
//   result    out        result_valid / result_stall  skac_pkg::out_item_t
//   cfg       in         cfg_write                cfg_index, cfg_data
//
// A table write completes at its transfer. Inside the knee a sample also
// passes S_KNEE2 and S_KNEE3, which the linear or inactive part skips; the
// steps follow the uses of the one shared multiplier and the two table reads.
// Reset clears the smoothed reduction and the registers; the tables hold
// garbage until written, so there is no clearing pass.
// A stalled result holds the sequencer in its last step; a new item is
// taken while a finished result still waits in the output register.
module soft_knee_audio_compressor_unit #(
    parameter int LEVEL_TABLE_DEPTH = skac_pkg::DEF_LEVEL_TABLE_DEPTH,
    parameter int LEVEL_INDEX_SHIFT = skac_pkg::DEF_LEVEL_INDEX_SHIFT,
    parameter int GAIN_TABLE_DEPTH  = skac_pkg::DEF_GAIN_TABLE_DEPTH,
    parameter int GAIN_INDEX_SHIFT  = skac_pkg::DEF_GAIN_INDEX_SHIFT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  skac_pkg::in_item_t                item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output skac_pkg::out_item_t               result,
    input  logic                              cfg_write,
    input  logic [skac_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [skac_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int LAW = $clog2(LEVEL_TABLE_DEPTH);
    localparam int GAW = $clog2(GAIN_TABLE_DEPTH);
    localparam int GIX_SHIFT = 8 + GAIN_INDEX_SHIFT;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEVEL,
        S_CURVE,
        S_KNEE2,
        S_KNEE3,
        S_CLAMP,
        S_FILTER,
        S_UPDATE,
        S_GAIN,
        S_SCALE,
        S_OUT
    } state_t;

    skac_pkg::cfg_t cfg;

    state_t               state_reg, state_next;
    logic signed [16:0]   o_reg, o_next;
    logic [14:0]          sq_reg, sq_next;
    logic                 active_reg, active_next;
    logic                 knee_reg, knee_next;
    logic [16:0]          mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [22:0]          x_reg, x_next;
    logic [23:0]          y_reg, y_next;
    logic                 result_valid_reg, result_valid_next;
    skac_pkg::out_item_t  result_reg, result_next;

    logic signed [skac_pkg::MUL_A_W-1:0] mul_a;
    logic signed [skac_pkg::MUL_B_W-1:0] mul_b;
    logic signed [skac_pkg::MUL_P_W-1:0] prod;

    logic             accept;
    logic             lvl_we, lvl_re;
    logic [LAW-1:0]   lvl_waddr, lvl_raddr;
    logic [15:0]      lvl_rdata;
    logic             gain_we, gain_re;
    logic [GAW-1:0]   gain_waddr, gain_raddr;
    logic [15:0]      gain_rdata;

    logic [16:0]        in_mag;
    logic [16:0]        lix_full;
    logic signed [16:0] in_db;
    logic signed [16:0] w_s;
    logic signed [16:0] o_now;
    logic [32:0]        red_full;
    logic [14:0]        red_sat;
    logic signed [24:0] diff;
    logic [15:0]        coef;
    logic [41:0]        total;
    logic signed [16:0] dbase;
    logic signed [24:0] dbase_sh;
    logic signed [25:0] d;
    logic [24:0]        gix_full;
    logic [18:0]        pm;
    logic               out_free;

    skac_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    skac_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (prod)
    );

    skac_ram #(
        .DEPTH (LEVEL_TABLE_DEPTH),
        .WIDTH (16)
    ) u_level_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (item.table_word),
        .re    (lvl_re),
        .raddr (lvl_raddr),
        .rdata (lvl_rdata)
    );

    skac_ram #(
        .DEPTH (GAIN_TABLE_DEPTH),
        .WIDTH (16)
    ) u_gain_ram (
        .clk   (clk),
        .we    (gain_we),
        .waddr (gain_waddr),
        .wdata (item.table_word),
        .re    (gain_re),
        .raddr (gain_raddr),
        .rdata (gain_rdata)
    );

    // Take items only between samples
    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;

    // Table writes land at the transfer edge; a later read always sees them
    assign lvl_waddr  = LAW'(item.table_index);
    assign gain_waddr = GAW'(item.table_index);
    assign lvl_we  = accept && (item.opcode == skac_pkg::OP_LEVEL_WR)
                     && (32'(item.table_index) < 32'(LEVEL_TABLE_DEPTH));
    assign gain_we = accept && (item.opcode == skac_pkg::OP_GAIN_WR)
                     && (32'(item.table_index) < 32'(GAIN_TABLE_DEPTH));

    // Level table address from the sample magnitude
    assign in_mag   = item.sample_in[15] ? (17'd0 - 17'(item.sample_in))
                                         : 17'(item.sample_in);
    assign lix_full = in_mag >> LEVEL_INDEX_SHIFT;
    assign lvl_re   = accept && (item.opcode == skac_pkg::OP_SAMPLE);
    assign lvl_raddr = (32'(lix_full) > 32'(LEVEL_TABLE_DEPTH - 1))
                       ? LAW'(LEVEL_TABLE_DEPTH - 1) : LAW'(lix_full);

    // Overshoot over the threshold
    assign in_db = 17'(signed'(lvl_rdata));
    assign w_s   = signed'({3'd0, cfg.knee_half_width});
    assign o_now = in_db - 17'(cfg.threshold_db);

    // Reduction from the curve product, saturated to Q8.8
    assign red_full = prod[48:16];
    always_comb
    begin
        if (!active_reg)
        begin
            red_sat = 15'd0;
        end
        else if (red_full > 33'd32767)
        begin
            red_sat = 15'h7FFF;
        end
        else
        begin
            red_sat = red_full[14:0];
        end
    end

    // One-pole smoothing folded to a single product: a*(y-x) + x<<16
    assign diff  = 25'(signed'({1'b0, y_reg})) - 25'(signed'({1'b0, x_reg}));
    assign coef  = ({1'b0, x_reg} > y_reg) ? cfg.attack_coef : cfg.release_coef;
    assign total = 42'({x_reg, 16'd0}) + prod[41:0];

    // Gain table address from makeup minus smoothed reduction
    assign dbase    = 17'(cfg.makeup_db) - 17'(cfg.gain_table_base_db);
    assign dbase_sh = {dbase, 8'd0};
    assign d        = 26'(dbase_sh) - 26'(signed'({1'b0, y_reg}));
    assign gix_full = d[24:0] >> GIX_SHIFT;
    assign gain_re  = (state_reg == S_GAIN);
    always_comb
    begin
        if (d <= 26'sd0)
        begin
            gain_raddr = '0;
        end
        else if (32'(gix_full) > 32'(GAIN_TABLE_DEPTH - 1))
        begin
            gain_raddr = GAW'(GAIN_TABLE_DEPTH - 1);
        end
        else
        begin
            gain_raddr = GAW'(gix_full);
        end
    end

    // Scaled magnitude
    assign pm = prod[30:12];

    // Route operands to the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_CURVE:
            begin
                if (knee_reg)
                begin
                    mul_a = signed'(skac_pkg::MUL_A_W'(sq_reg));
                    mul_b = signed'(skac_pkg::MUL_B_W'(sq_reg));
                end
                else
                begin
                    mul_a = signed'(skac_pkg::MUL_A_W'(o_reg[15:0]));
                    mul_b = signed'({1'b0, cfg.slope});
                end
            end
            S_KNEE2:
            begin
                mul_a = signed'({1'b0, prod[29:0]});
                mul_b = signed'({2'b0, cfg.inv_four_width});
            end
            S_KNEE3:
            begin
                mul_a = signed'({5'd0, prod[45:20]});
                mul_b = signed'({1'b0, cfg.slope});
            end
            S_FILTER:
            begin
                mul_a = skac_pkg::MUL_A_W'(diff);
                mul_b = signed'({2'b0, coef});
            end
            // Keep the scaled product steady while the final step waits
            S_SCALE, S_OUT:
            begin
                mul_a = signed'(skac_pkg::MUL_A_W'(mag_reg));
                mul_b = signed'({2'b0, gain_rdata});
            end
            default: ;
        endcase
    end

    // Sequence one sample through the curve, the filter and the gain lookup
    always_comb
    begin
        state_next        = state_reg;
        o_next            = o_reg;
        sq_next           = sq_reg;
        active_next       = active_reg;
        knee_next         = knee_reg;
        mag_next          = mag_reg;
        neg_next          = neg_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        // Drop the result once it transfers
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (lvl_re)
                begin
                    mag_next   = in_mag;
                    neg_next   = item.sample_in[15];
                    state_next = S_LEVEL;
                end
            end
            S_LEVEL:
            begin
                o_next      = o_now;
                sq_next     = 15'(o_now + w_s);
                active_next = (o_now > -w_s);
                knee_next   = (o_now > -w_s) && (o_now < w_s);
                state_next  = S_CURVE;
            end
            S_CURVE:
            begin
                state_next = knee_reg ? S_KNEE2 : S_CLAMP;
            end
            S_KNEE2:
            begin
                state_next = S_KNEE3;
            end
            S_KNEE3:
            begin
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                x_next     = {red_sat, 8'd0};
                state_next = S_FILTER;
            end
            S_FILTER:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                y_next     = total[39:16];
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    if (neg_reg)
                    begin
                        result_next.sample_out = (pm > 19'd32768)
                            ? -16'sd32768 : signed'(16'(19'd0 - pm));
                    end
                    else
                    begin
                        result_next.sample_out = (pm > 19'd32767)
                            ? 16'sd32767 : signed'(pm[15:0]);
                    end
                    result_next.compressing = active_reg;
                    result_valid_next       = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, datapath registers and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            o_reg            <= '0;
            sq_reg           <= '0;
            active_reg       <= 1'b0;
            knee_reg         <= 1'b0;
            mag_reg          <= '0;
            neg_reg          <= 1'b0;
            x_reg            <= '0;
            y_reg            <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            o_reg            <= o_next;
            sq_reg           <= sq_next;
            active_reg       <= active_next;
            knee_reg         <= knee_next;
            mag_reg          <= mag_next;
            neg_reg          <= neg_next;
            x_reg            <= x_next;
            y_reg            <= y_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A new result only comes out of the final step
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    // A sample transfer starts the sequence and blocks further items
    a_sample_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.opcode == skac_pkg::OP_SAMPLE) |=> item_stall)
        else $error("sample transfer did not start the sequence");

    // The smoothed reduction moves only in the update step
    a_y_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(y_reg) |-> $past(state_reg == S_UPDATE))
        else $error("smoothed reduction changed outside the update step");

    // Inside the knee means above the knee start
    a_knee_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_LEVEL && knee_reg) |-> active_reg)
        else $error("knee flag without compression flag");

endmodule
